### rtl/ppr_pkg.sv
`timescale 1ns / 1ps

package ppr_pkg;

  localparam int unsigned NumLanes  = 4;
  localparam int unsigned NumLevels = 256;
  localparam int unsigned WordW     = 64;
  localparam int unsigned IdxW      = 3;

  typedef logic [7:0]           level_t;
  typedef logic [NumLevels-1:0] levels_t;
  typedef logic [WordW-1:0]     word_t;
  typedef logic [IdxW-1:0]      cfg_idx_t;
  typedef level_t [NumLanes-1:0] pixel_t;

  localparam cfg_idx_t CfgLevelWord0 = 3'd0;
  localparam cfg_idx_t CfgLevelWord1 = 3'd1;
  localparam cfg_idx_t CfgLevelWord2 = 3'd2;
  localparam cfg_idx_t CfgLevelWord3 = 3'd3;
  localparam cfg_idx_t CfgDither     = 3'd4;

  localparam int unsigned LaneRed   = 0;
  localparam int unsigned LaneGreen = 1;
  localparam int unsigned LaneBlue  = 2;
  localparam int unsigned LaneAlpha = 3;

  localparam word_t  Word0Reset = 64'h0000_0000_0000_0001;
  localparam word_t  Word3Reset = 64'h8000_0000_0000_0000;
  localparam level_t TopLevel   = 8'hff;
  localparam level_t ClearValue = 8'h00;

  typedef struct packed {
    logic valid;
    logic dith;
    logic odd;
  } ctrl_t;

  // highest set bit
  function automatic level_t find_high(levels_t vec);
    level_t res;
    res = '0;
    for (int k = 0; k < NumLevels; k++) begin
      if (vec[k]) begin
        res = level_t'(k);
      end
    end
    return res;
  endfunction

  // lowest set bit, top level when empty
  function automatic level_t find_low(levels_t vec);
    level_t res;
    res = TopLevel;
    for (int k = NumLevels - 1; k >= 0; k--) begin
      if (vec[k]) begin
        res = level_t'(k);
      end
    end
    return res;
  endfunction

endpackage

### rtl/ppr_lane.sv
`timescale 1ns / 1ps

module ppr_lane (
  input  logic            clk_i,
  input  ppr_pkg::levels_t levels_i,
  input  ppr_pkg::level_t  v_i,
  input  ppr_pkg::ctrl_t   ctrl_i,
  output ppr_pkg::level_t  q_o
);

  ppr_pkg::levels_t at_or_below;
  ppr_pkg::level_t  lo_d, hi_d, lo_q, hi_q, v_q;
  ppr_pkg::level_t  dlo, dhi;
  logic [8:0]       dlo2, dhi2;
  logic             pick_lo;

  // level search
  always_comb begin
    for (int k = 0; k < ppr_pkg::NumLevels; k++) begin
      at_or_below[k] = (ppr_pkg::level_t'(k) <= v_i);
    end
    lo_d = ppr_pkg::find_high(levels_i & at_or_below);
    hi_d = ppr_pkg::find_low(levels_i & ~at_or_below);
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    v_q  <= v_i;
  end

  // rounding decision
  always_comb begin
    dlo  = v_q - lo_q;
    dhi  = hi_q - v_q;
    dlo2 = {dlo, 1'b0};
    dhi2 = {dhi, 1'b0};
    if (!ctrl_i.dith) begin
      pick_lo = (dlo < dhi);
    end else if (ctrl_i.odd) begin
      pick_lo = ({1'b0, dlo} < dhi2);
    end else begin
      pick_lo = !({1'b0, dhi} <= dlo2);
    end
    q_o = pick_lo ? lo_q : hi_q;
  end

endmodule

### rtl/ppr_merge.sv
`timescale 1ns / 1ps

module ppr_merge (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  ppr_pkg::pixel_t pix_i,
  output logic            valid_o,
  output ppr_pkg::pixel_t pix_o
);

  logic            valid_q;
  ppr_pkg::pixel_t pix_d, pix_q;

  // cleared alpha zeroes the whole pixel
  always_comb begin
    if (pix_i[ppr_pkg::LaneAlpha] == ppr_pkg::ClearValue) begin
      pix_d = '0;
    end else begin
      pix_d = pix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule

### rtl/posterize_pixel_remap.sv
`timescale 1ns / 1ps

// pipeline: a registered level search stage, then a registered decision and merge stage, from start to result_valid_o
// throughput: one pixel per cycle, four channel lanes work in parallel; busy is never raised
// the receiver cannot stall; each result is shown for exactly one cycle
// reset: asynchronous active low, clears the pipeline valids and loads the level set
// with only levels 0 and 255 and dither off

module posterize_pixel_remap (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [7:0]          red_in_i,
  input  logic [7:0]          green_in_i,
  input  logic [7:0]          blue_in_i,
  input  logic [7:0]          alpha_in_i,
  input  logic                row_parity_i,
  input  logic                column_parity_i,
  input  logic                cfg_we_i,
  input  ppr_pkg::cfg_idx_t   cfg_idx_i,
  input  ppr_pkg::word_t      cfg_wdata_i,
  output logic                result_valid_o,
  output logic [7:0]          red_out_o,
  output logic [7:0]          green_out_o,
  output logic [7:0]          blue_out_o,
  output logic [7:0]          alpha_out_o
);

  ppr_pkg::word_t   word0_q, word1_q, word2_q, word3_q;
  logic             dith_q;
  ppr_pkg::levels_t levels;
  ppr_pkg::pixel_t  pix_in, pix_lane, pix_out;
  ppr_pkg::ctrl_t   ctrl_d, ctrl_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word0_q <= ppr_pkg::Word0Reset;
      word1_q <= '0;
      word2_q <= '0;
      word3_q <= ppr_pkg::Word3Reset;
      dith_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ppr_pkg::CfgLevelWord0: word0_q <= cfg_wdata_i;
        ppr_pkg::CfgLevelWord1: word1_q <= cfg_wdata_i;
        ppr_pkg::CfgLevelWord2: word2_q <= cfg_wdata_i;
        ppr_pkg::CfgLevelWord3: word3_q <= cfg_wdata_i;
        ppr_pkg::CfgDither:     dith_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // end levels always allowed
  always_comb begin
    levels = {word3_q, word2_q, word1_q, word0_q};
    levels[0] = 1'b1;
    levels[ppr_pkg::NumLevels-1] = 1'b1;
  end

  assign pix_in[ppr_pkg::LaneRed]   = red_in_i;
  assign pix_in[ppr_pkg::LaneGreen] = green_in_i;
  assign pix_in[ppr_pkg::LaneBlue]  = blue_in_i;
  assign pix_in[ppr_pkg::LaneAlpha] = alpha_in_i;

  assign ctrl_d.valid = start & ~busy;
  assign ctrl_d.dith  = dith_q;
  assign ctrl_d.odd   = row_parity_i ^ column_parity_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  for (genvar g = 0; g < ppr_pkg::NumLanes; g++) begin : g_lane
    ppr_lane u_lane (
      .clk_i    (clk_i),
      .levels_i (levels),
      .v_i      (pix_in[g]),
      .ctrl_i   (ctrl_q),
      .q_o      (pix_lane[g])
    );
  end

  ppr_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ctrl_q.valid),
    .pix_i   (pix_lane),
    .valid_o (result_valid_o),
    .pix_o   (pix_out)
  );

  assign red_out_o   = pix_out[ppr_pkg::LaneRed];
  assign green_out_o = pix_out[ppr_pkg::LaneGreen];
  assign blue_out_o  = pix_out[ppr_pkg::LaneBlue];
  assign alpha_out_o = pix_out[ppr_pkg::LaneAlpha];

endmodule
